[rtl/core/point_pool_free_list_assert.svh]
// assertion macros used by the free list pool allocator
`ifndef POINT_POOL_FREE_LIST_ASSERT_SVH
`define POINT_POOL_FREE_LIST_ASSERT_SVH

// same-cycle implication, idle during reset
`define PPFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define PPFL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ppfl_pkg.sv]
// types and constants of the free list pool allocator
`timescale 1ns / 1ps

package ppfl_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int FILL_W  = 11;
    localparam int BATCH_W = 6;

    // register index decoded from the byte address
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REBUILD = 2'd2,
        CMD_COUNT   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_WAIT,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              ok;
        logic [FILL_W-1:0] free_slots;
        logic [FILL_W-1:0] lost_slots;
        logic              last;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

[rtl/core/ppfl_link_ram.sv]
// next-slot link memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module ppfl_link_ram #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  ppfl_pkg::t_mem_cmd               i_mem,
    input  logic [$clog2(POOL_DEPTH)-1:0]    i_waddr,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]  i_wdata,
    input  logic [$clog2(POOL_DEPTH)-1:0]    i_raddr,
    output logic [$clog2(POOL_DEPTH+1)-1:0]  o_rdata
);

    localparam int LW = $clog2(POOL_DEPTH + 1);

    logic [LW-1:0] r_mem [POOL_DEPTH];
    logic [LW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ppfl_ctrl.sv]
// command sequencer: head, free count, pop loop and rebuild sweep
`timescale 1ns / 1ps
`include "point_pool_free_list_assert.svh"

module ppfl_ctrl #(
    parameter int POOL_DEPTH = 1024,
    parameter int MAX_BATCH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ppfl_pkg::CMD_W-1:0]           i_cmd,
    input  logic [ppfl_pkg::SLOT_W-1:0]          i_slot_in,
    input  logic [ppfl_pkg::BATCH_W-1:0]         i_alloc_count,
    input  logic [ppfl_pkg::FILL_W-1:0]          i_pool_size,
    output logic                                 o_res_valid,
    output ppfl_pkg::t_result                    o_res,
    input  logic                                 i_res_ready,
    output ppfl_pkg::t_mem_cmd                   o_mem,
    output logic [$clog2(POOL_DEPTH)-1:0]        o_waddr,
    output logic [$clog2(POOL_DEPTH+1)-1:0]      o_wdata,
    output logic [$clog2(POOL_DEPTH)-1:0]        o_raddr,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]      i_rdata
);

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int RW = $clog2(MAX_BATCH + 1);

    ppfl_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_head,  n_head;
    logic [LW-1:0]    r_total, n_total;
    logic [RW-1:0]    r_rem,   n_rem;
    logic [AW-1:0]    r_idx,   n_idx;
    logic [LW-1:0]    r_n,     n_n;

    ppfl_pkg::t_cmd   cmd;
    logic             accept;
    logic             alloc_ok;
    logic             free_ok;
    logic [LW-1:0]    pool_eff;
    logic [LW-1:0]    lost;
    logic [LW-1:0]    total_inc;
    logic [AW-1:0]    head_slot;
    logic [LW-1:0]    link_next;
    logic             sweep_end;

    assign cmd      = ppfl_pkg::t_cmd'(i_cmd);
    assign o_ready  = (r_state == ppfl_pkg::ST_IDLE) && i_res_ready;
    assign accept   = i_valid && o_ready;

    // all-or-nothing: refuse an empty run, one above MAX_BATCH, or one the free list cannot cover
    assign alloc_ok = (i_alloc_count != '0)
                   && (32'(i_alloc_count) <= 32'(MAX_BATCH))
                   && (32'(i_alloc_count) <= 32'(r_total));
    assign free_ok  = (32'(i_slot_in) < 32'(POOL_DEPTH))
                   && (32'(r_total) < 32'(POOL_DEPTH));

    assign pool_eff  = (32'(i_pool_size) > 32'(POOL_DEPTH)) ? LW'(POOL_DEPTH)
                                                            : LW'(i_pool_size);
    assign lost      = (pool_eff > r_total) ? LW'(pool_eff - r_total) : '0;
    assign total_inc = LW'(r_total + LW'(1));
    // null head reads as slot 0, stray links fall back to slot 0
    assign head_slot = (r_head < LW'(POOL_DEPTH)) ? AW'(r_head) : '0;
    assign link_next = (i_rdata > LW'(POOL_DEPTH)) ? '0 : i_rdata;
    assign sweep_end = (r_idx == AW'(r_n - LW'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppfl_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((cmd == ppfl_pkg::CMD_ALLOC) && alloc_ok) begin
                        n_state = ppfl_pkg::ST_POP;
                    end else if ((cmd == ppfl_pkg::CMD_REBUILD) && (pool_eff != '0)) begin
                        n_state = ppfl_pkg::ST_SWEEP;
                    end
                end
            end
            ppfl_pkg::ST_POP: begin
                if (i_res_ready) begin
                    n_state = ppfl_pkg::ST_WAIT;
                end
            end
            ppfl_pkg::ST_WAIT: begin
                n_state = (r_rem == RW'(1)) ? ppfl_pkg::ST_IDLE : ppfl_pkg::ST_POP;
            end
            ppfl_pkg::ST_SWEEP: begin
                if (sweep_end) begin
                    n_state = ppfl_pkg::ST_EMIT;
                end
            end
            ppfl_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ppfl_pkg::ST_IDLE;
                end
            end
            default: n_state = ppfl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_total = r_total;
        n_rem   = r_rem;
        n_idx   = r_idx;
        n_n     = r_n;
        unique case (r_state)
            ppfl_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        ppfl_pkg::CMD_ALLOC: begin
                            if (alloc_ok) begin
                                n_total = LW'(r_total - LW'(i_alloc_count));
                                n_rem   = RW'(i_alloc_count);
                            end
                        end
                        ppfl_pkg::CMD_FREE: begin
                            if (free_ok) begin
                                n_head  = LW'(i_slot_in);
                                n_total = total_inc;
                            end
                        end
                        ppfl_pkg::CMD_REBUILD: begin
                            n_total = pool_eff;
                            n_head  = (pool_eff != '0) ? '0 : LW'(POOL_DEPTH);
                            n_n     = pool_eff;
                            n_idx   = '0;
                        end
                        ppfl_pkg::CMD_COUNT: begin
                        end
                    endcase
                end
            end
            ppfl_pkg::ST_WAIT: begin
                n_head = link_next;
                n_rem  = RW'(r_rem - RW'(1));
            end
            ppfl_pkg::ST_SWEEP: begin
                n_idx = AW'(r_idx + AW'(1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        o_mem       = '0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_raddr     = head_slot;
        unique case (r_state)
            ppfl_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        ppfl_pkg::CMD_ALLOC: begin
                            o_res_valid      = !alloc_ok;
                            o_res.free_slots = ppfl_pkg::FILL_W'(r_total);
                        end
                        ppfl_pkg::CMD_FREE: begin
                            o_res_valid      = 1'b1;
                            o_res.slot_out   = i_slot_in;
                            o_res.ok         = free_ok;
                            o_res.free_slots = free_ok ? ppfl_pkg::FILL_W'(total_inc)
                                                       : ppfl_pkg::FILL_W'(r_total);
                            o_mem.wr_en      = free_ok;
                            o_waddr          = AW'(i_slot_in);
                            o_wdata          = r_head;
                        end
                        ppfl_pkg::CMD_REBUILD: begin
                            // empty pool finishes at once, otherwise after the sweep
                            o_res_valid = (pool_eff == '0);
                            o_res.ok    = 1'b1;
                        end
                        ppfl_pkg::CMD_COUNT: begin
                            o_res_valid      = 1'b1;
                            o_res.ok         = 1'b1;
                            o_res.free_slots = ppfl_pkg::FILL_W'(r_total);
                            o_res.lost_slots = ppfl_pkg::FILL_W'(lost);
                        end
                    endcase
                end
            end
            ppfl_pkg::ST_POP: begin
                o_res_valid      = 1'b1;
                o_res.slot_out   = ppfl_pkg::SLOT_W'(head_slot);
                o_res.ok         = 1'b1;
                o_res.free_slots = ppfl_pkg::FILL_W'(r_total);
                o_res.last       = (r_rem == RW'(1));
                o_mem.rd_en      = i_res_ready;
            end
            ppfl_pkg::ST_SWEEP: begin
                o_mem.wr_en = 1'b1;
                o_waddr     = r_idx;
                o_wdata     = sweep_end ? LW'(POOL_DEPTH) : LW'(LW'(r_idx) + LW'(1));
            end
            ppfl_pkg::ST_EMIT: begin
                o_res_valid      = 1'b1;
                o_res.ok         = 1'b1;
                o_res.free_slots = ppfl_pkg::FILL_W'(r_total);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppfl_pkg::ST_IDLE;
            r_head  <= LW'(POOL_DEPTH);
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_idx <= n_idx;
        r_n   <= n_n;
    end

    `PPFL_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= LW'(POOL_DEPTH), "free count above pool depth")
    `PPFL_ASSERT_NXT(a_read_then_wait, i_clk, i_rst_n, o_mem.rd_en, r_state == ppfl_pkg::ST_WAIT, "link read not followed by head update")
    `PPFL_ASSERT_IMP(a_pop_pending, i_clk, i_rst_n, r_state == ppfl_pkg::ST_POP, r_rem != '0, "pop with no handles left")
    `PPFL_ASSERT_NXT(a_total_hold, i_clk, i_rst_n, !accept, $stable(r_total), "free count moved without a transaction")

endmodule

[rtl/core/ppfl_out_reg.sv]
// result register between the sequencer and the output channel
`timescale 1ns / 1ps

module ppfl_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_res_valid,
    input  ppfl_pkg::t_result             i_res,
    output logic                          o_res_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppfl_pkg::SLOT_W-1:0]   o_slot_out,
    output logic                          o_ok,
    output logic [ppfl_pkg::FILL_W-1:0]   o_free_slots,
    output logic [ppfl_pkg::FILL_W-1:0]   o_lost_slots,
    output logic                          o_last
);

    logic              r_valid;
    ppfl_pkg::t_result r_res;

    // loads when empty or when the held transaction leaves this cycle
    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid      = r_valid;
    assign o_slot_out   = r_res.slot_out;
    assign o_ok         = r_res.ok;
    assign o_free_slots = r_res.free_slots;
    assign o_lost_slots = r_res.lost_slots;
    assign o_last       = r_res.last;

endmodule

[rtl/core/point_pool_free_list.sv]
// top level of the free list pool allocator with its register port
//
//  channel   direction  handshake               payload
//  in        input      i_valid / o_ready       i_cmd, i_slot_in, i_alloc_count
//  out       output     o_valid / i_ready       o_slot_out, o_ok, o_free_slots,
//                                               o_lost_slots, o_last
//  cfg       input      psel, penable, pwrite   paddr, pwdata, prdata (pready high)
//
// free, count and refused alloc: result loaded into the output register in the next cycle
// alloc of k handles: POP emits a handle and reads its link, WAIT makes that link the new head
// rebuild: one link write per slot for min(pool_size, POOL_DEPTH) slots, then the result
// reset empties the list at once; the link memory is not cleared
// a full output register stalls the sequencer, input is taken only when idle
`timescale 1ns / 1ps

module point_pool_free_list #(
    parameter int POOL_DEPTH = 1024,
    parameter int MAX_BATCH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ppfl_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ppfl_pkg::SLOT_W-1:0]   i_slot_in,
    input  logic [ppfl_pkg::BATCH_W-1:0]  i_alloc_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppfl_pkg::SLOT_W-1:0]   o_slot_out,
    output logic                          o_ok,
    output logic [ppfl_pkg::FILL_W-1:0]   o_free_slots,
    output logic [ppfl_pkg::FILL_W-1:0]   o_lost_slots,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);

    logic [ppfl_pkg::FILL_W-1:0] r_pool_size;

    logic               res_valid;
    ppfl_pkg::t_result  res;
    logic               res_ready;
    ppfl_pkg::t_mem_cmd mem;
    logic [AW-1:0]      waddr;
    logic [LW-1:0]      wdata;
    logic [AW-1:0]      raddr;
    logic [LW-1:0]      rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ppfl_pkg::REG_POOL_SIZE) ? 32'(r_pool_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == ppfl_pkg::REG_POOL_SIZE)) begin
            r_pool_size <= pwdata[ppfl_pkg::FILL_W-1:0];
        end
    end

    ppfl_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .MAX_BATCH  (MAX_BATCH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_slot_in     (i_slot_in),
        .i_alloc_count (i_alloc_count),
        .i_pool_size   (r_pool_size),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (res_ready),
        .o_mem         (mem),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata)
    );

    ppfl_link_ram #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_mem   (mem),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ppfl_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_res_ready  (res_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot_out   (o_slot_out),
        .o_ok         (o_ok),
        .o_free_slots (o_free_slots),
        .o_lost_slots (o_lost_slots),
        .o_last       (o_last)
    );

endmodule
